[rtl/rcr_pkg.sv]
`timescale 1ns / 1ps

package rcr_pkg;

    // Defaults for the top level parameters
    localparam int MAX_COLS_DEF  = 256;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Widest values the parameter ranges allow; command fields are sized for them
    localparam int DIM_W_MAX  = 10;
    localparam int FRAC_MAX   = 16;
    localparam int COORD_W    = DIM_W_MAX + FRAC_MAX + 2;
    localparam int ADDR_W_MAX = 2 * DIM_W_MAX;

    // Port field widths
    localparam int IN_COORD_W = 20;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    localparam logic [CFG_W-1:0]  CANVAS_W_RST = 9'd256;
    localparam logic [CFG_W-1:0]  CANVAS_H_RST = 9'd256;
    localparam logic [CHAR_W-1:0] BG_RST       = 8'd32;

    // Operations
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [CHAR_W-1:0] KIND_FILLED  = 8'h52;
    localparam logic [CHAR_W-1:0] KIND_OUTLINE = 8'h72;

    // Result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // Back-end commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_REPLY = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [CFG_W-1:0]  canvas_width;
        logic [CFG_W-1:0]  canvas_height;
        logic [CHAR_W-1:0] background_char;
    } t_cfg;

    // Rectangle bounds are precomputed so the sweep only compares:
    // inside when lo <= p <= hi, border when p < lo_in or p > hi_in.
    typedef struct packed {
        logic [1:0]            cmd;
        logic                  outline;
        logic [CHAR_W-1:0]     paint;
        logic [1:0]            status;
        t_coord                x_lo;
        t_coord                x_hi;
        t_coord                x_lo_in;
        t_coord                x_hi_in;
        t_coord                y_lo;
        t_coord                y_hi;
        t_coord                y_lo_in;
        t_coord                y_hi_in;
        logic [DIM_W_MAX-1:0]  last_col;
        logic [DIM_W_MAX-1:0]  last_row;
        logic [ADDR_W_MAX-1:0] addr;
    } t_cmd;

endpackage

[rtl/rcr_intf.sv]
`timescale 1ns / 1ps

interface rcr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             operation;
    logic [rcr_pkg::CHAR_W-1:0]             shape_kind;
    logic signed [rcr_pkg::IN_COORD_W-1:0]  rect_left;
    logic signed [rcr_pkg::IN_COORD_W-1:0]  rect_top;
    logic signed [rcr_pkg::IN_COORD_W-1:0]  rect_span_x;
    logic signed [rcr_pkg::IN_COORD_W-1:0]  rect_span_y;
    logic [rcr_pkg::CHAR_W-1:0]             paint_char;
    logic [7:0]                             pixel_col;
    logic [7:0]                             pixel_row;

    modport source (
        output valid, operation, shape_kind, rect_left, rect_top, rect_span_x,
               rect_span_y, paint_char, pixel_col, pixel_row,
        input  ready
    );
    modport sink (
        input  valid, operation, shape_kind, rect_left, rect_top, rect_span_x,
               rect_span_y, paint_char, pixel_col, pixel_row,
        output ready
    );
endinterface

interface rcr_out_if;
    logic                       valid;
    logic                       ready;
    logic [rcr_pkg::CHAR_W-1:0] pixel_value;
    logic [1:0]                 status;

    modport source (
        output valid, pixel_value, status,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, status,
        output ready
    );
endinterface

[rtl/rcr_front.sv]
`timescale 1ns / 1ps

module rcr_front #(
    parameter int MAX_COLS  = rcr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rcr_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rcr_pkg::FRAC_BITS_DEF
) (
    rcr_in_if.sink         s_cmd,
    input  rcr_pkg::t_cfg  i_cfg,
    input  logic           i_busy,
    input  logic           i_full,
    output logic           o_push,
    output rcr_pkg::t_cmd  o_cmd
);

    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);

    logic [CCW-1:0]  w_cols;
    logic [RCW-1:0]  w_rows;
    logic            w_empty_canvas;
    logic            w_bad_rect;
    logic            w_read_in;
    rcr_pkg::t_coord w_one;
    rcr_pkg::t_coord w_x0;
    rcr_pkg::t_coord w_y0;
    rcr_pkg::t_coord w_x1;
    rcr_pkg::t_coord w_y1;

    // Active canvas, clipped to the store size
    assign w_cols = (32'(i_cfg.canvas_width) > 32'(MAX_COLS)) ? CCW'(MAX_COLS)
                                                             : CCW'(i_cfg.canvas_width);
    assign w_rows = (32'(i_cfg.canvas_height) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                              : RCW'(i_cfg.canvas_height);
    assign w_empty_canvas = (w_cols == '0) || (w_rows == '0);

    assign w_one = rcr_pkg::t_coord'(32'd1 << FRAC_BITS);
    assign w_x0  = rcr_pkg::t_coord'(s_cmd.rect_left);
    assign w_y0  = rcr_pkg::t_coord'(s_cmd.rect_top);
    assign w_x1  = w_x0 + rcr_pkg::t_coord'(s_cmd.rect_span_x);
    assign w_y1  = w_y0 + rcr_pkg::t_coord'(s_cmd.rect_span_y);

    assign w_bad_rect = s_cmd.rect_span_x[rcr_pkg::IN_COORD_W-1] || (s_cmd.rect_span_x == '0)
                     || s_cmd.rect_span_y[rcr_pkg::IN_COORD_W-1] || (s_cmd.rect_span_y == '0)
                     || ((s_cmd.shape_kind != rcr_pkg::KIND_FILLED)
                         && (s_cmd.shape_kind != rcr_pkg::KIND_OUTLINE));

    assign w_read_in = (32'(s_cmd.pixel_col) < 32'(w_cols))
                    && (32'(s_cmd.pixel_row) < 32'(w_rows));

    assign s_cmd.ready = !i_full && !i_busy;
    assign o_push      = s_cmd.valid && s_cmd.ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.outline  = (s_cmd.shape_kind == rcr_pkg::KIND_OUTLINE);
        o_cmd.paint    = s_cmd.paint_char;
        o_cmd.x_lo     = w_x0;
        o_cmd.x_hi     = w_x1;
        o_cmd.x_lo_in  = w_x0 + w_one;
        o_cmd.x_hi_in  = w_x1 - w_one;
        o_cmd.y_lo     = w_y0;
        o_cmd.y_hi     = w_y1;
        o_cmd.y_lo_in  = w_y0 + w_one;
        o_cmd.y_hi_in  = w_y1 - w_one;
        o_cmd.last_col = rcr_pkg::DIM_W_MAX'(w_cols - CCW'(1));
        o_cmd.last_row = rcr_pkg::DIM_W_MAX'(w_rows - RCW'(1));
        o_cmd.addr     = rcr_pkg::ADDR_W_MAX'(32'(s_cmd.pixel_row) * 32'(MAX_COLS)
                                              + 32'(s_cmd.pixel_col));
        o_cmd.status   = rcr_pkg::ST_OK;
        o_cmd.cmd      = rcr_pkg::CMD_REPLY;
        unique case (s_cmd.operation)
            rcr_pkg::OP_CLEAR: begin
                o_cmd.cmd = rcr_pkg::CMD_CLEAR;
            end
            rcr_pkg::OP_DRAW: begin
                if (w_bad_rect) begin
                    o_cmd.status = rcr_pkg::ST_REJECT;
                end else if (!w_empty_canvas) begin
                    o_cmd.cmd = rcr_pkg::CMD_DRAW;
                end
            end
            rcr_pkg::OP_READ: begin
                if (w_read_in) begin
                    o_cmd.cmd = rcr_pkg::CMD_READ;
                end else begin
                    o_cmd.status = rcr_pkg::ST_OUTSIDE;
                end
            end
            rcr_pkg::OP_NONE: begin
                o_cmd.cmd = rcr_pkg::CMD_REPLY;
            end
            default: begin
                o_cmd.cmd = rcr_pkg::CMD_REPLY;
            end
        endcase
    end

endmodule

[rtl/rcr_fifo.sv]
`timescale 1ns / 1ps

module rcr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rcr_pkg::t_cmd o_data
);

    localparam int PW = $clog2(rcr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rcr_pkg::QUEUE_DEPTH + 1);

    rcr_pkg::t_cmd r_mem [rcr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(rcr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/rcr_back.sv]
`timescale 1ns / 1ps

module rcr_back #(
    parameter int MAX_COLS  = rcr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rcr_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rcr_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rcr_pkg::CHAR_W-1:0] i_background,
    input  logic                       i_empty,
    input  rcr_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_busy,
    rcr_out_if.source                  m_res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_DRAW  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_REPLY = 3'd3;
    localparam logic [2:0] S_IDLE  = 3'd4;

    logic [rcr_pkg::CHAR_W-1:0] r_mem [DEPTH];

    logic [2:0]                 r_state,     n_state;
    logic                       r_init,      n_init;
    logic [AW-1:0]              r_addr,      n_addr;
    logic [AW-1:0]              r_row_base,  n_row_base;
    logic [CIW-1:0]             r_col,       n_col;
    logic [RIW-1:0]             r_row,       n_row;
    rcr_pkg::t_cmd              r_cmd,       n_cmd;
    logic [1:0]                 r_res_st,    n_res_st;
    logic                       r_from_mem,  n_from_mem;
    logic                       r_out_valid, n_out_valid;
    logic [rcr_pkg::CHAR_W-1:0] r_out_pixel, n_out_pixel;
    logic [1:0]                 r_out_st,    n_out_st;
    logic [rcr_pkg::CHAR_W-1:0] r_rdata;

    logic                       w_we;
    logic [rcr_pkg::CHAR_W-1:0] w_wdata;
    logic                       w_slot_free;
    rcr_pkg::t_coord            w_p;
    rcr_pkg::t_coord            w_q;
    logic                       w_inside;
    logic                       w_edge;
    logic                       w_paint;

    assign w_p = rcr_pkg::t_coord'({r_col, {FRAC_BITS{1'b0}}});
    assign w_q = rcr_pkg::t_coord'({r_row, {FRAC_BITS{1'b0}}});

    assign w_inside = (w_p >= r_cmd.x_lo) && (w_p <= r_cmd.x_hi)
                   && (w_q >= r_cmd.y_lo) && (w_q <= r_cmd.y_hi);
    assign w_edge   = (w_p < r_cmd.x_lo_in) || (w_p > r_cmd.x_hi_in)
                   || (w_q < r_cmd.y_lo_in) || (w_q > r_cmd.y_hi_in);
    assign w_paint  = w_inside && (!r_cmd.outline || w_edge);

    assign w_slot_free = !r_out_valid || m_res.ready;

    assign m_res.valid       = r_out_valid;
    assign m_res.pixel_value = r_out_pixel;
    assign m_res.status      = r_out_st;
    assign o_busy            = r_init;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_addr      = r_addr;
        n_row_base  = r_row_base;
        n_col       = r_col;
        n_row       = r_row;
        n_cmd       = r_cmd;
        n_res_st    = r_res_st;
        n_from_mem  = r_from_mem;
        n_out_valid = r_out_valid && !m_res.ready;
        n_out_pixel = r_out_pixel;
        n_out_st    = r_out_st;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_wdata     = r_cmd.paint;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_res_st   = i_cmd.status;
                    n_from_mem = 1'b0;
                    n_addr     = '0;
                    n_row_base = '0;
                    n_col      = '0;
                    n_row      = '0;
                    unique case (i_cmd.cmd)
                        rcr_pkg::CMD_CLEAR: n_state = S_CLEAR;
                        rcr_pkg::CMD_DRAW:  n_state = S_DRAW;
                        rcr_pkg::CMD_READ: begin
                            n_addr     = i_cmd.addr[AW-1:0];
                            n_from_mem = 1'b1;
                            n_state    = S_READ;
                        end
                        rcr_pkg::CMD_REPLY: n_state = S_REPLY;
                        default:            n_state = S_REPLY;
                    endcase
                end
            end
            S_CLEAR: begin
                // reset pass always uses the reset background, config may move meanwhile
                w_we    = 1'b1;
                w_wdata = r_init ? rcr_pkg::BG_RST : i_background;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_REPLY;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAW: begin
                w_we = w_paint;
                if (r_col == r_cmd.last_col[CIW-1:0]) begin
                    if (r_row == r_cmd.last_row[RIW-1:0]) begin
                        n_state = S_REPLY;
                    end else begin
                        n_col      = '0;
                        n_row      = r_row + RIW'(1);
                        n_row_base = r_row_base + AW'(MAX_COLS);
                        n_addr     = r_row_base + AW'(MAX_COLS);
                    end
                end else begin
                    n_col  = r_col + CIW'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            S_READ: begin
                // r_rdata picks up the cell at this edge
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = r_from_mem ? r_rdata : '0;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_row_base  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_row_base  <= n_row_base;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_res_st    <= n_res_st;
        r_from_mem  <= n_from_mem;
        r_out_pixel <= n_out_pixel;
        r_out_st    <= n_out_st;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

endmodule

[rtl/rectangle_canvas_rasterizer.sv]
`timescale 1ns / 1ps

// Character canvas with clear, draw-rectangle and read-pixel operations, one
// result per item. The canvas is a single-port memory of MAX_COLS*MAX_ROWS
// characters that is touched one cell per cycle: a clear sweeps the whole
// store (65536 cells by default), a draw visits every active pixel (active
// columns times active rows, up to 65536), a read fetches one cell and a
// rejected rectangle or empty canvas touches none, plus the transfer out.
// After reset the block runs the same sweep to fill the store with the reset
// background and accepts no item until it is done; configuration writes are
// taken at any time but are meant to change only while the block is idle.
// A two-entry command queue sits between the decode front and the canvas
// engine, and the result register lets the next items queue while a result
// waits to be taken.
module rectangle_canvas_rasterizer #(
    parameter int MAX_COLS  = rcr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rcr_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rcr_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rcr_in_if.sink                        i_cmd,
    rcr_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcr_pkg::CFG_W-1:0]     i_cfg_data
);

    rcr_pkg::t_cfg r_cfg;
    rcr_pkg::t_cmd w_front_cmd;
    rcr_pkg::t_cmd w_queue_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic          w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width    <= rcr_pkg::CANVAS_W_RST;
            r_cfg.canvas_height   <= rcr_pkg::CANVAS_H_RST;
            r_cfg.background_char <= rcr_pkg::BG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcr_pkg::CFG_WIDTH:  r_cfg.canvas_width    <= i_cfg_data;
                rcr_pkg::CFG_HEIGHT: r_cfg.canvas_height   <= i_cfg_data;
                rcr_pkg::CFG_BG:     r_cfg.background_char <= i_cfg_data[rcr_pkg::CHAR_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    rcr_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .s_cmd  (i_cmd),
        .i_cfg  (r_cfg),
        .i_busy (w_busy),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_front_cmd)
    );

    rcr_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_queue_cmd)
    );

    rcr_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_background (r_cfg.background_char),
        .i_empty      (w_empty),
        .i_cmd        (w_queue_cmd),
        .o_pop        (w_pop),
        .o_busy       (w_busy),
        .m_res        (o_res)
    );

`ifndef SYNTHESIS
    a_no_transfer_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !(i_cmd.valid && i_cmd.ready))
        else $error("input transfer during reset fill");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_full || w_pop))
        else $error("command queue overflow");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command queue underflow");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != rcr_pkg::ST_OK)) |-> (o_res.pixel_value == '0))
        else $error("nonzero pixel on error status");
`endif

endmodule

[dv/rectangle_canvas_rasterizer_tb.sv]
`timescale 1ns / 1ps

module rectangle_canvas_rasterizer_tb;

    localparam int CANVAS_COLS = rcr_pkg::MAX_COLS_DEF;
    localparam int CANVAS_ROWS = rcr_pkg::MAX_ROWS_DEF;
    localparam int FRAC        = rcr_pkg::FRAC_BITS_DEF;
    localparam int ONE         = 1 << FRAC;
    localparam longint TIMEOUT_NS = 50_000_000;

    // index 3 decodes to no register
    localparam logic [rcr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // wide enough for left+span and pixel-minus-edge without wrap
    typedef logic signed [rcr_pkg::IN_COORD_W+1:0] t_span;

    typedef struct packed {
        logic [1:0]                            op;
        logic [rcr_pkg::CHAR_W-1:0]            kind;
        logic signed [rcr_pkg::IN_COORD_W-1:0] left;
        logic signed [rcr_pkg::IN_COORD_W-1:0] top;
        logic signed [rcr_pkg::IN_COORD_W-1:0] span_x;
        logic signed [rcr_pkg::IN_COORD_W-1:0] span_y;
        logic [rcr_pkg::CHAR_W-1:0]            paint;
        logic [7:0]                            col;
        logic [7:0]                            row;
    } t_canvas_cmd;

    typedef struct packed {
        logic [rcr_pkg::CHAR_W-1:0] value;
        logic [1:0]                 status;
    } t_canvas_result;

    typedef struct packed {
        t_canvas_cmd    cmd;
        logic           typed_exp;
        t_canvas_result want;
    } t_dir_row;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_SPARSE} t_sink_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                          cfg_we;
    logic [rcr_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rcr_pkg::CFG_W-1:0]     cfg_data;

    rcr_in_if  cmd_if ();
    rcr_out_if res_if ();

    rectangle_canvas_rasterizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block state
    logic [rcr_pkg::CHAR_W-1:0] canvas_mirror [CANVAS_COLS*CANVAS_ROWS];
    logic [rcr_pkg::CFG_W-1:0]  cfg_cols;
    logic [rcr_pkg::CFG_W-1:0]  cfg_rows;
    logic [rcr_pkg::CHAR_W-1:0] cfg_bg;

    t_canvas_result pending_replies [$];
    t_dir_row       dir_rows [$];

    int fail_count        = 0;
    int burst_left        = 0;
    bit steady_feed       = 1'b0;
    int result_hold_req   = 0;
    int random_items      = 0;
    int clear_phases_left = 2;
    int spare_clears      = 1;

    function automatic int active_cols();
        return (int'(cfg_cols) > CANVAS_COLS) ? CANVAS_COLS : int'(cfg_cols);
    endfunction

    function automatic int active_rows();
        return (int'(cfg_rows) > CANVAS_ROWS) ? CANVAS_ROWS : int'(cfg_rows);
    endfunction

    function automatic t_canvas_result predict_canvas_op(input t_canvas_cmd c);
        t_canvas_result r;
        int ncols;
        int nrows;
        t_span x0, y0, x1, y1, p, q;
        logic covered;
        logic border;
        r = '0;
        ncols = active_cols();
        nrows = active_rows();
        case (c.op)
            rcr_pkg::OP_CLEAR: begin
                foreach (canvas_mirror[k]) canvas_mirror[k] = cfg_bg;
            end
            rcr_pkg::OP_DRAW: begin
                if ($signed(c.span_x) <= 0 || $signed(c.span_y) <= 0 ||
                    (c.kind != rcr_pkg::KIND_FILLED &&
                     c.kind != rcr_pkg::KIND_OUTLINE)) begin
                    r.status = rcr_pkg::ST_REJECT;
                end else begin
                    x0 = $signed(c.left);
                    y0 = $signed(c.top);
                    x1 = x0 + $signed(c.span_x);
                    y1 = y0 + $signed(c.span_y);
                    for (int j = 0; j < nrows; j++) begin
                        q = t_span'(j * ONE);
                        for (int i = 0; i < ncols; i++) begin
                            p = t_span'(i * ONE);
                            covered = (p >= x0) && (p <= x1) && (q >= y0) && (q <= y1);
                            // border: closer than one pixel to any edge
                            border = covered && ((p - x0 < ONE) || (x1 - p < ONE) ||
                                                 (q - y0 < ONE) || (y1 - q < ONE));
                            if (border || (covered && c.kind == rcr_pkg::KIND_FILLED))
                                canvas_mirror[j * CANVAS_COLS + i] = c.paint;
                        end
                    end
                end
            end
            rcr_pkg::OP_READ: begin
                if (int'(c.col) < ncols && int'(c.row) < nrows)
                    r.value = canvas_mirror[int'(c.row) * CANVAS_COLS + int'(c.col)];
                else
                    r.status = rcr_pkg::ST_OUTSIDE;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_canvas_cmd plain_cmd(input logic [1:0] op);
        t_canvas_cmd c;
        c = '0;
        c.op = op;
        return c;
    endfunction

    function automatic t_canvas_cmd read_cmd(input logic [7:0] col, input logic [7:0] row);
        t_canvas_cmd c;
        c = plain_cmd(rcr_pkg::OP_READ);
        c.col = col;
        c.row = row;
        return c;
    endfunction

    function automatic t_canvas_cmd draw_cmd(input logic [rcr_pkg::CHAR_W-1:0] kind,
                                             input logic [rcr_pkg::IN_COORD_W-1:0] l,
                                             input logic [rcr_pkg::IN_COORD_W-1:0] t,
                                             input logic [rcr_pkg::IN_COORD_W-1:0] sx,
                                             input logic [rcr_pkg::IN_COORD_W-1:0] sy,
                                             input logic [rcr_pkg::CHAR_W-1:0] paint);
        t_canvas_cmd c;
        c = plain_cmd(rcr_pkg::OP_DRAW);
        c.kind   = kind;
        c.left   = l;
        c.top    = t;
        c.span_x = sx;
        c.span_y = sy;
        c.paint  = paint;
        return c;
    endfunction

    function automatic t_canvas_cmd random_cmd(input int nc, input int nr);
        t_canvas_cmd c;
        int roll;
        int l;
        int t;
        int s;
        int x;
        roll = $urandom_range(0, 99);
        c = '0;
        if (roll < 20 || roll >= 97) begin
            // noise: every field random
            c.op     = 2'($urandom);
            c.kind   = 8'($urandom);
            c.left   = 20'($urandom);
            c.top    = 20'($urandom);
            c.span_x = 20'($urandom);
            c.span_y = 20'($urandom);
            c.paint  = 8'($urandom);
            c.col    = 8'($urandom);
            c.row    = 8'($urandom);
            if (roll >= 97) begin
                c.op = rcr_pkg::OP_NONE;
            end else if (c.op == rcr_pkg::OP_CLEAR) begin
                if (spare_clears != 0) spare_clears--;
                else c.op = rcr_pkg::OP_READ;
            end
        end else if (roll < 60) begin
            c.op   = rcr_pkg::OP_DRAW;
            c.kind = ($urandom_range(0, 1) != 0) ? rcr_pkg::KIND_FILLED
                                                 : rcr_pkg::KIND_OUTLINE;
            l = $urandom_range(0, (nc + 3) * ONE) - 2 * ONE;
            t = $urandom_range(0, (nr + 3) * ONE) - 2 * ONE;
            // whole-pixel corners land exactly on pixel centers
            if ($urandom_range(0, 1) != 0) l = l & ~(ONE - 1);
            if ($urandom_range(0, 1) != 0) t = t & ~(ONE - 1);
            c.left = 20'(l);
            c.top  = 20'(t);
            s = $urandom_range(1, (nc + 1) * ONE);
            if ($urandom_range(0, 1) != 0) s = (s / ONE + 1) * ONE;
            c.span_x = 20'(s);
            s = $urandom_range(1, (nr + 1) * ONE);
            if ($urandom_range(0, 1) != 0) s = (s / ONE + 1) * ONE;
            c.span_y = 20'(s);
            c.paint  = 8'($urandom);
        end else begin
            c.op = rcr_pkg::OP_READ;
            x = $urandom_range(0, nc + 1);
            c.col = 8'((x > 255) ? 255 : x);
            x = $urandom_range(0, nr + 1);
            c.row = 8'((x > 255) ? 255 : x);
        end
        return c;
    endfunction

    task automatic add_row(input t_canvas_cmd c, input logic typed_exp,
                           input logic [rcr_pkg::CHAR_W-1:0] value,
                           input logic [1:0] status);
        t_dir_row r;
        r.cmd          = c;
        r.typed_exp    = typed_exp;
        r.want.value   = value;
        r.want.status  = status;
        dir_rows.push_back(r);
    endtask

    // Called right after a rising edge; returns at the edge of the transfer.
    task automatic send_cmd(input t_canvas_cmd c, input logic typed_exp,
                            input t_canvas_result want);
        t_canvas_result got;
        if (!steady_feed && burst_left == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left != 0) burst_left--;
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= c.op;
        cmd_if.shape_kind  <= c.kind;
        cmd_if.rect_left   <= c.left;
        cmd_if.rect_top    <= c.top;
        cmd_if.rect_span_x <= c.span_x;
        cmd_if.rect_span_y <= c.span_y;
        cmd_if.paint_char  <= c.paint;
        cmd_if.pixel_col   <= c.col;
        cmd_if.pixel_row   <= c.row;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        got = predict_canvas_op(c);
        pending_replies.push_back(typed_exp ? want : got);
    endtask

    task automatic write_reg(input logic [rcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcr_pkg::CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rcr_pkg::CFG_WIDTH:  cfg_cols = data;
            rcr_pkg::CFG_HEIGHT: cfg_rows = data;
            rcr_pkg::CFG_BG:     cfg_bg   = data[rcr_pkg::CHAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [rcr_pkg::CFG_W-1:0] w,
                             input logic [rcr_pkg::CFG_W-1:0] h,
                             input logic [rcr_pkg::CHAR_W-1:0] bg, input bit with_clear,
                             input int n_items, input bit squeeze);
        t_canvas_result no_exp;
        int nc;
        int nr;
        no_exp = '0;
        // drain before touching the registers
        cmd_if.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(rcr_pkg::CFG_WIDTH, w);
        write_reg(rcr_pkg::CFG_HEIGHT, h);
        write_reg(rcr_pkg::CFG_BG, {1'b0, bg});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 9'($urandom));
        cfg_we <= 1'b0;
        nc = active_cols();
        nr = active_rows();
        burst_left  = 0;
        steady_feed = squeeze || ($urandom_range(0, 3) == 0);
        // result side holds off while items keep coming, so the input backs up
        if (squeeze) result_hold_req = 300;
        if (with_clear) send_cmd(plain_cmd(rcr_pkg::OP_CLEAR), 1'b0, no_exp);
        repeat (n_items) begin
            send_cmd(random_cmd(nc, nr), 1'b0, no_exp);
            random_items++;
        end
        steady_feed = 1'b0;
    endtask

    task automatic flag_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_canvas_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("unexpected transfer, pixel_value", 0, int'(res_if.pixel_value));
            end else begin
                want = pending_replies.pop_front();
                if (res_if.pixel_value !== want.value)
                    flag_mismatch("pixel_value", int'(want.value), int'(res_if.pixel_value));
                if (res_if.status !== want.status)
                    flag_mismatch("status", int'(want.status), int'(res_if.status));
            end
        end
    end

    initial begin : result_sink
        t_sink_mode mode;
        int mode_left;
        int hold_left;
        logic rdy;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_hold_req != 0) begin
                hold_left       = result_hold_req;
                result_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   rdy = 1'b1;
                    SINK_COIN:   rdy = 1'($urandom_range(0, 1));
                    SINK_COMB:   rdy = (mode_left % 4) != 0;
                    default:     rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        bit with_clear;
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= rcr_pkg::CFG_WIDTH;
        cfg_data <= '0;
        cmd_if.valid       <= 1'b0;
        cmd_if.operation   <= rcr_pkg::OP_NONE;
        cmd_if.shape_kind  <= '0;
        cmd_if.rect_left   <= '0;
        cmd_if.rect_top    <= '0;
        cmd_if.rect_span_x <= '0;
        cmd_if.rect_span_y <= '0;
        cmd_if.paint_char  <= '0;
        cmd_if.pixel_col   <= '0;
        cmd_if.pixel_row   <= '0;
        cfg_cols = rcr_pkg::CANVAS_W_RST;
        cfg_rows = rcr_pkg::CANVAS_H_RST;
        cfg_bg   = rcr_pkg::BG_RST;
        foreach (canvas_mirror[k]) canvas_mirror[k] = rcr_pkg::BG_RST;

        // reset canvas is 256x256 filled with blanks
        add_row(read_cmd(8'd0, 8'd0), 1'b1, 8'h20, rcr_pkg::ST_OK);
        add_row(read_cmd(8'd255, 8'd255), 1'b1, 8'h20, rcr_pkg::ST_OK);
        add_row(plain_cmd(rcr_pkg::OP_NONE), 1'b1, 8'h00, rcr_pkg::ST_OK);
        add_row(draw_cmd(8'h00, 20'h0, 20'h0, 20'h100, 20'h100, 8'h23),
                1'b1, 8'h00, rcr_pkg::ST_REJECT);
        add_row(draw_cmd(rcr_pkg::KIND_FILLED, 20'h0, 20'h0, 20'h0, 20'h100, 8'h23),
                1'b1, 8'h00, rcr_pkg::ST_REJECT);
        add_row(draw_cmd(rcr_pkg::KIND_OUTLINE, 20'h0, 20'h0, 20'h100, 20'hFFFFF, 8'h23),
                1'b1, 8'h00, rcr_pkg::ST_REJECT);
        add_row(draw_cmd(rcr_pkg::KIND_FILLED, 20'h0, 20'h0, 20'h80000, 20'h100, 8'h23),
                1'b1, 8'h00, rcr_pkg::ST_REJECT);
        add_row(draw_cmd(8'hFF, 20'h0, 20'h0, 20'h100, 20'h100, 8'h23),
                1'b1, 8'h00, rcr_pkg::ST_REJECT);
        // fill the whole canvas, then a fractional outline over it
        add_row(draw_cmd(rcr_pkg::KIND_FILLED, 20'h0, 20'h0, 20'h7FFFF, 20'h7FFFF, 8'hFF),
                1'b0, 0, 0);
        add_row(read_cmd(8'd255, 8'd255), 1'b0, 0, 0);
        add_row(draw_cmd(rcr_pkg::KIND_OUTLINE, 20'h00A80, 20'h01440, 20'h01EC0,
                         20'h00580, 8'h41),
                1'b0, 0, 0);
        add_row(read_cmd(8'd10, 8'd20), 1'b0, 0, 0);
        add_row(read_cmd(8'd11, 8'd21), 1'b0, 0, 0);
        add_row(read_cmd(8'd20, 8'd23), 1'b0, 0, 0);
        add_row(read_cmd(8'd41, 8'd25), 1'b0, 0, 0);
        add_row(read_cmd(8'd42, 8'd25), 1'b0, 0, 0);
        // most negative corner: right and bottom edges end at -1, nothing covered
        add_row(draw_cmd(rcr_pkg::KIND_FILLED, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF,
                         8'h00),
                1'b0, 0, 0);
        add_row(read_cmd(8'd0, 8'd0), 1'b0, 0, 0);
        add_row(plain_cmd(rcr_pkg::OP_CLEAR), 1'b1, 8'h00, rcr_pkg::ST_OK);
        add_row(read_cmd(8'd128, 8'd64), 1'b1, 8'h20, rcr_pkg::ST_OK);
        add_row(read_cmd(8'd0, 8'd255), 1'b1, 8'h20, rcr_pkg::ST_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_cmd(dir_rows[k].cmd, dir_rows[k].typed_exp, dir_rows[k].want);

        run_phase(9'd0, 9'd1, 8'h00, 1'b1, 8, 1'b0);
        run_phase(9'd511, 9'd1, 8'hFF, 1'b1, 10, 1'b0);
        run_phase(9'd3, 9'd0, 8'h41, 1'b0, 6, 1'b0);
        run_phase(9'd2, 9'd511, 8'h07, 1'b0, 10, 1'b1);
        run_phase(9'd256, 9'd2, 8'h80, 1'b0, 8, 1'b0);
        while (random_items < 75) begin
            with_clear = (clear_phases_left > 0) && ($urandom_range(0, 2) == 0);
            if (with_clear) clear_phases_left--;
            run_phase(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), 8'($urandom),
                      with_clear, $urandom_range(8, 16), 1'b0);
        end

        cmd_if.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
rtl/rcr_pkg.sv
rtl/rcr_intf.sv
rtl/rcr_front.sv
rtl/rcr_fifo.sv
rtl/rcr_back.sv
rtl/rectangle_canvas_rasterizer.sv
dv/rectangle_canvas_rasterizer_tb.sv
